// ----- hdl/wsdf_pkg.sv -----
// Shared types and constants for the WebSocket frame deframer.
// Used by the deframer top level, its port checkers and its testbench; depends on nothing else.

package wsdf_pkg;

   // Field widths of one beat
   localparam int BYTE_W     = 8;
   localparam int OPCODE_W   = 4;
   localparam int CODE_W     = 16;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 2;

   // Header codes
   localparam logic [OPCODE_W-1:0] OPC_CLOSE     = 4'h8;
   localparam logic [CODE_W-1:0]   DEFAULT_CLOSE = 16'd1000;
   localparam logic [6:0]          LEN_EXT16     = 7'd126;
   localparam logic [6:0]          LEN_EXT64     = 7'd127;

   // Header byte counts
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] KEY_LEN     = 4'd4;

   // Result beat payload, packed into rsp_tdata from bit 0 upwards:
   // payload_byte [7:0], frame_opcode [11:8], final_fragment [12], status_code [28:13].
   typedef struct packed {
      logic [CODE_W-1:0]   status_code;
      logic                final_fragment;
      logic [OPCODE_W-1:0] frame_opcode;
      logic [BYTE_W-1:0]   payload_byte;
   } rsp_item_type;

   localparam int RSP_PAD_W = RSP_DATA_W - $bits(rsp_item_type);

   // Result beat flags in rsp_tuser: has_byte [0], truncated [1].
   typedef struct packed {
      logic truncated;
      logic has_byte;
   } rsp_flags_type;

endpackage

// ----- hdl/websocket_frame_deframer.sv -----
// WebSocket (RFC 6455) receive-side frame deframer, one byte per beat.
// Depends on wsdf_pkg for field widths, header codes and the result beat layout.
//
// The block takes one received byte per beat, with req_tlast marking the last byte
// of a chunk that carries one frame. It parses the two header bytes, the 16-bit or
// 64-bit big-endian extended length and the masking key, then emits each payload
// byte unmasked together with the frame opcode and FIN bit; rsp_tlast marks the
// final beat of the frame and, for close frames, that beat carries the close code
// (1000 when the payload has fewer than two bytes). A frame without payload gives
// one empty last beat. A chunk that ends early gives a last beat flagged truncated,
// and bytes after the end of the frame are dropped until the chunk ends. The block
// takes one byte every clock cycle while rsp_tready does not stall the output; an
// accepted byte waits in the input register until the parse step can run, and the
// parse step then loads the output register. The clock period is set by the
// combinational parse step, whose longest path is the LENGTH_BITS-wide decrement
// and compare of the remaining payload length.

module websocket_frame_deframer
   import wsdf_pkg::*;
#(
   parameter int LENGTH_BITS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   // Received bytes: tdata = byte_in [7:0]; tlast = chunk_end
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   // Results: tdata = payload_byte [7:0], frame_opcode [11:8], final_fragment [12],
   // status_code [28:13], zero [31:29]; tuser = has_byte [0], truncated [1]; tlast = last
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser,
   output logic                  rsp_tlast
);

   typedef enum logic [2:0] {
      PH_HDR1,
      PH_HDR2,
      PH_EXTLEN,
      PH_KEY,
      PH_BODY,
      PH_DONE
   } phase_type;

   localparam logic [LENGTH_BITS-1:0] LEFT_ZERO = '0;
   localparam logic [LENGTH_BITS-1:0] LEFT_ONE  = {{(LENGTH_BITS-1){1'b0}}, 1'b1};

   // Input register
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_end_ff;

   // Parser state
   phase_type               phase_ff, phase_in;
   logic [OPCODE_W-1:0]     opcode_ff, opcode_in;
   logic                    fin_ff, fin_in;
   logic                    mask_ff, mask_in;
   logic [3:0]              hdr_left_ff, hdr_left_in;
   logic [LENGTH_BITS-1:0]  left_ff, left_in;
   logic [1:0]              idx_ff, idx_in;
   logic                    ge2_ff, ge2_in;
   logic [31:0]             key_ff, key_in;
   logic [CODE_W-1:0]       code_ff, code_in;

   // Output register
   logic          rsp_valid_ff;
   rsp_item_type  rsp_item_ff;
   rsp_flags_type rsp_flags_ff;
   logic          rsp_last_ff;

   // Result of the current step
   logic          emit;
   rsp_item_type  res_item;
   rsp_flags_type res_flags;
   logic          res_last;

   logic              out_adv;
   logic              step;
   logic [BYTE_W-1:0] mask_byte;
   logic [BYTE_W-1:0] plain;
   logic [6:0]        len7;
   logic              al_go;
   logic              al_mask;
   logic              al_zero;

   // Handshake: a byte moves on whenever the output register is free or draining
   assign out_adv    = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_adv;
   assign req_tready = !in_valid_ff || step;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_item_ff};
   assign rsp_tuser  = rsp_flags_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Key byte for this payload position, most significant first
   always_comb begin
      case (idx_ff)
         2'd0:    mask_byte = key_ff[31:24];
         2'd1:    mask_byte = key_ff[23:16];
         2'd2:    mask_byte = key_ff[15:8];
         default: mask_byte = key_ff[7:0];
      endcase
   end

   assign plain = mask_ff ? (in_byte_ff ^ mask_byte) : in_byte_ff;
   assign len7  = in_byte_ff[6:0];

   // One parse step for the byte in the input register
   always_comb begin
      phase_in    = phase_ff;
      opcode_in   = opcode_ff;
      fin_in      = fin_ff;
      mask_in     = mask_ff;
      hdr_left_in = hdr_left_ff;
      left_in     = left_ff;
      idx_in      = idx_ff;
      ge2_in      = ge2_ff;
      key_in      = key_ff;
      code_in     = code_ff;
      emit        = 1'b0;
      res_item    = '0;
      res_flags   = '0;
      res_last    = 1'b0;
      al_go       = 1'b0;
      al_mask     = 1'b0;
      al_zero     = 1'b0;

      unique case (phase_ff)
         PH_HDR1: begin
            fin_in      = in_byte_ff[7];
            opcode_in   = in_byte_ff[3:0];
            mask_in     = 1'b0;
            key_in      = '0;
            left_in     = '0;
            idx_in      = '0;
            ge2_in      = 1'b0;
            hdr_left_in = '0;
            code_in     = DEFAULT_CLOSE;
            phase_in    = PH_HDR2;
         end
         PH_HDR2: begin
            mask_in = in_byte_ff[7];
            if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
               hdr_left_in = (len7 == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
               left_in     = '0;
               phase_in    = PH_EXTLEN;
            end else begin
               left_in = {{(LENGTH_BITS-7){1'b0}}, len7};
               al_go   = 1'b1;
               al_mask = in_byte_ff[7];
               al_zero = (len7 == 7'd0);
            end
         end
         PH_EXTLEN: begin
            left_in     = {left_ff[LENGTH_BITS-BYTE_W-1:0], in_byte_ff};
            hdr_left_in = hdr_left_ff - 4'd1;
            if (hdr_left_ff == 4'd1) begin
               al_go   = 1'b1;
               al_mask = mask_ff;
               al_zero = (left_in == LEFT_ZERO);
            end
         end
         PH_KEY: begin
            key_in      = {key_ff[23:0], in_byte_ff};
            hdr_left_in = hdr_left_ff - 4'd1;
            if (hdr_left_ff == 4'd1) begin
               al_go   = 1'b1;
               al_mask = 1'b0;
               al_zero = (left_ff == LEFT_ZERO);
            end
         end
         PH_BODY: begin
            // The first two payload bytes form the close code
            if (!ge2_ff && idx_ff == 2'd0) begin
               code_in = {plain, 8'h00};
            end else if (!ge2_ff && idx_ff == 2'd1) begin
               code_in = {code_ff[15:8], plain};
            end
            idx_in  = idx_ff + 2'd1;
            ge2_in  = ge2_ff || (idx_ff == 2'd1);
            left_in = left_ff - LEFT_ONE;
            emit               = 1'b1;
            res_item.payload_byte = plain;
            res_flags.has_byte = 1'b1;
            if (left_ff == LEFT_ONE) begin
               res_last = 1'b1;
               phase_in = PH_DONE;
               if (opcode_ff == OPC_CLOSE) begin
                  res_item.status_code = ge2_in ? code_in : DEFAULT_CLOSE;
               end
            end
         end
         PH_DONE: begin
            // Trailing bytes of the chunk are dropped
         end
         default: begin
            phase_in = PH_HDR1;
         end
      endcase

      // Length known: go on to the key, the payload or an empty last beat
      if (al_go) begin
         if (al_mask) begin
            phase_in    = PH_KEY;
            hdr_left_in = KEY_LEN;
         end else if (al_zero) begin
            phase_in = PH_DONE;
            emit     = 1'b1;
            res_last = 1'b1;
            if (opcode_ff == OPC_CLOSE) begin
               res_item.status_code = DEFAULT_CLOSE;
            end
         end else begin
            phase_in = PH_BODY;
         end
      end

      // Chunk end: close off an unfinished frame and wait for the next header
      if (in_end_ff) begin
         if (phase_ff != PH_DONE && !(emit && res_last)) begin
            if (!emit) begin
               res_item = '0;
               res_flags.has_byte = 1'b0;
            end
            emit                 = 1'b1;
            res_last             = 1'b1;
            res_flags.truncated  = 1'b1;
            res_item.status_code = '0;
         end
         phase_in = PH_HDR1;
      end

      res_item.frame_opcode   = opcode_in;
      res_item.final_fragment = fin_in;
   end

   // Input register, parser state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         phase_ff     <= PH_HDR1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (step) begin
            phase_ff <= phase_in;
         end
         if (out_adv) begin
            rsp_valid_ff <= step && emit;
         end
      end
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata[BYTE_W-1:0];
         in_end_ff  <= req_tlast;
      end
      if (step) begin
         opcode_ff   <= opcode_in;
         fin_ff      <= fin_in;
         mask_ff     <= mask_in;
         hdr_left_ff <= hdr_left_in;
         left_ff     <= left_in;
         idx_ff      <= idx_in;
         ge2_ff      <= ge2_in;
         key_ff      <= key_in;
         code_ff     <= code_in;
      end
      if (step && emit) begin
         rsp_item_ff  <= res_item;
         rsp_flags_ff <= res_flags;
         rsp_last_ff  <= res_last;
      end
   end

endmodule

// ----- hdl/wsdf_checker.sv -----
// Port checker for the WebSocket frame deframer, bound to the top level.
// Depends on wsdf_pkg for the result beat layout and the close opcode.

module wsdf_checker
   import wsdf_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser,
   input logic                  rsp_tlast
);

   // A stalled result beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // No result beat straight after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result beat presented after reset");

   // A truncated beat always ends the frame
   a_trunc_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast)
      else $error("truncated beat without end of frame");

   // An empty beat carries no byte
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[7:0] == 8'h00)
      else $error("empty beat with non-zero byte");

   // A close code appears only on the clean last beat of a close frame
   a_close_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[28:13] != 16'h0000
         |-> rsp_tlast && !rsp_tuser[1] && rsp_tdata[11:8] == OPC_CLOSE)
      else $error("close code outside the last beat of a close frame");

endmodule

bind websocket_frame_deframer wsdf_checker u_wsdf_checker (.*);

// ----- dv/wsdf_frame_checker.sv -----
// Port checker for the WebSocket frame deframer: predicts result beats from accepted bytes.
// Depends on wsdf_pkg for field widths, header codes and the result beat layout.

module wsdf_frame_checker
   import wsdf_pkg::*;
#(
   parameter int LENGTH_BITS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic [RSP_USER_W-1:0] rsp_tuser,
   input  logic                  rsp_tlast,
   output int                    fail_count,
   output int                    beats_pending,
   output int                    beats_checked,
   output int                    truncated_beats
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] LEN_MASK = {64{1'b1}} >> (64 - LENGTH_BITS);

   typedef enum logic [2:0] {
      PH_HDR1,
      PH_HDR2,
      PH_EXTLEN,
      PH_KEY,
      PH_BODY,
      PH_DONE
   } rx_phase_type;

   // One predicted result beat
   typedef struct packed {
      logic [BYTE_W-1:0]   data;
      logic                has;
      logic [OPCODE_W-1:0] opcode;
      logic                fin;
      logic                last;
      logic                trunc;
      logic [CODE_W-1:0]   code;
   } frame_beat_type;

   frame_beat_type   beat_q[$];
   int               mismatches;
   int               checked;
   int               truncs;

   // Parser state mirrored from the block
   rx_phase_type        rx_phase;
   logic [OPCODE_W-1:0] hdr_opcode;
   logic                hdr_fin;
   logic                hdr_masked;
   logic [3:0]          hdr_left;
   logic [63:0]         body_left;
   logic [63:0]         body_index;
   logic [31:0]         mask_word;
   logic [CODE_W-1:0]   close_word;

   function automatic frame_beat_type make_beat(input logic [BYTE_W-1:0] data, input logic has,
                                                input logic last, input logic trunc,
                                                input logic [CODE_W-1:0] code);
      frame_beat_type r;
      r.data   = data;
      r.has    = has;
      r.opcode = hdr_opcode;
      r.fin    = hdr_fin;
      r.last   = last;
      r.trunc  = trunc;
      r.code   = code;
      return r;
   endfunction

   // Close status carried by the final beat of a frame.
   function automatic logic [CODE_W-1:0] close_status();
      if (hdr_opcode != OPC_CLOSE) begin
         return '0;
      end
      return (body_index >= 64'd2) ? close_word : DEFAULT_CLOSE;
   endfunction

   // Length (and key, if any) are known: move on to the key, the payload or an empty last beat.
   task automatic header_complete(input logic need_key, output logic got,
                                  output frame_beat_type r);
      got = 1'b0;
      r   = '0;
      if (need_key) begin
         rx_phase = PH_KEY;
         hdr_left = KEY_LEN;
      end else if (body_left == '0) begin
         rx_phase = PH_DONE;
         r        = make_beat('0, 1'b0, 1'b1, 1'b0, close_status());
         got      = 1'b1;
      end else begin
         rx_phase = PH_BODY;
      end
   endtask

   task automatic reset_parser();
      rx_phase   = PH_HDR1;
      hdr_opcode = '0;
      hdr_fin    = 1'b0;
      hdr_masked = 1'b0;
      hdr_left   = '0;
      body_left  = '0;
      body_index = '0;
      mask_word  = '0;
      close_word = DEFAULT_CLOSE;
   endtask

   // Advance the parser by one received byte and queue the beat it causes, if any.
   task automatic deframe_byte(input logic [BYTE_W-1:0] b, input logic chunk_end);
      rx_phase_type   entry_phase;
      logic           got;
      frame_beat_type r;
      logic [6:0]     len7;
      logic [7:0]     v;
      logic           done;
      int             k;
      entry_phase = rx_phase;
      got = 1'b0;
      r = '0;
      case (rx_phase)
         PH_HDR1: begin
            hdr_fin    = b[7];
            hdr_opcode = b[3:0];
            hdr_masked = 1'b0;
            mask_word  = '0;
            body_left  = '0;
            body_index = '0;
            hdr_left   = '0;
            close_word = DEFAULT_CLOSE;
            rx_phase   = PH_HDR2;
         end
         PH_HDR2: begin
            len7       = b[6:0];
            hdr_masked = b[7];
            if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
               hdr_left  = (len7 == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
               body_left = '0;
               rx_phase  = PH_EXTLEN;
            end else begin
               body_left = 64'(len7) & LEN_MASK;
               header_complete(hdr_masked, got, r);
            end
         end
         PH_EXTLEN: begin
            body_left = {body_left[55:0], b} & LEN_MASK;
            hdr_left  = hdr_left - 4'd1;
            if (hdr_left == '0) begin
               header_complete(hdr_masked, got, r);
            end
         end
         PH_KEY: begin
            mask_word = {mask_word[23:0], b};
            hdr_left  = hdr_left - 4'd1;
            if (hdr_left == '0) begin
               header_complete(1'b0, got, r);
            end
         end
         PH_BODY: begin
            // Key bytes are applied most significant first.
            k = 3 - int'(body_index[1:0]);
            v = hdr_masked ? (b ^ mask_word[8*k +: 8]) : b;
            if (body_index == 64'd0) begin
               close_word = {v, 8'h00};
            end else if (body_index == 64'd1) begin
               close_word[7:0] = v;
            end
            body_index = body_index + 64'd1;
            body_left  = body_left - 64'd1;
            done       = (body_left == '0);
            if (done) begin
               rx_phase = PH_DONE;
            end
            r   = make_beat(v, 1'b1, done, 1'b0, done ? close_status() : '0);
            got = 1'b1;
         end
         default: begin
         end
      endcase

      // The chunk ending before the frame did marks the frame truncated.
      if (chunk_end) begin
         if (entry_phase != PH_DONE && !(got && r.last)) begin
            if (got) begin
               r.last  = 1'b1;
               r.trunc = 1'b1;
               r.code  = '0;
            end else begin
               r   = make_beat('0, 1'b0, 1'b1, 1'b1, '0);
               got = 1'b1;
            end
         end
         rx_phase = PH_HDR1;
      end
      if (got) begin
         beat_q.insert(beat_q.size(), r);
      end
   endtask

   // Compare one accepted result beat with the oldest prediction.
   task automatic compare_beat();
      rsp_item_type   item;
      rsp_flags_type  flags;
      logic [RSP_PAD_W-1:0] pad;
      frame_beat_type want;
      logic           bad;
      item  = rsp_tdata[$bits(rsp_item_type)-1:0];
      pad   = rsp_tdata[RSP_DATA_W-1 -: RSP_PAD_W];
      flags = rsp_tuser;
      if (beat_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("Unexpected result beat: tdata %h tuser %b tlast %b",
                     rsp_tdata, rsp_tuser, rsp_tlast);
         end
      end else begin
         want = beat_q.pop_front();
         checked++;
         if (want.trunc) begin
            truncs++;
         end
         bad = (item.payload_byte !== want.data) || (flags.has_byte !== want.has) ||
               (item.frame_opcode !== want.opcode) || (item.final_fragment !== want.fin) ||
               (rsp_tlast !== want.last) || (flags.truncated !== want.trunc) ||
               (item.status_code !== want.code) || (pad !== '0);
         if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display({"Beat %0d mismatch: expected byte %h has %b opc %h fin %b",
                         " last %b trunc %b code %0d"},
                        checked, want.data, want.has, want.opcode, want.fin, want.last,
                        want.trunc, want.code);
               $display("   got byte %h has %b opc %h fin %b last %b trunc %b code %0d pad %b",
                        item.payload_byte, flags.has_byte, item.frame_opcode,
                        item.final_fragment, rsp_tlast, flags.truncated, item.status_code,
                        pad);
            end
         end
      end
   endtask

   // Watch both channels; results are compared before the new byte is predicted.
   always @(posedge clock) begin
      if (reset) begin
         reset_parser();
         beat_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            compare_beat();
         end
         if (req_tvalid && req_tready) begin
            deframe_byte(req_tdata[BYTE_W-1:0], req_tlast);
         end
      end
      fail_count      <= mismatches;
      beats_pending   <= beat_q.size();
      beats_checked   <= checked;
      truncated_beats <= truncs;
   end

endmodule

// ----- dv/websocket_frame_deframer_tb.sv -----
// Top of the WebSocket frame deframer testbench: clock, reset, byte stimulus and verdict.
// Depends on wsdf_pkg, the websocket_frame_deframer block and the wsdf_frame_checker module.

module websocket_frame_deframer_tb
   import wsdf_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LEN_BITS     = 64;
   localparam int ITEM_TARGET  = 900;
   localparam int PRESSURE_AT  = 300;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 32;
   localparam int CYCLE_LIMIT  = 200000;

   localparam logic [OPCODE_W-1:0] OPC_CONT   = 4'h0;
   localparam logic [OPCODE_W-1:0] OPC_TEXT   = 4'h1;
   localparam logic [OPCODE_W-1:0] OPC_BINARY = 4'h2;
   localparam logic [OPCODE_W-1:0] OPC_PONG   = 4'hA;
   localparam logic [OPCODE_W-1:0] OPC_TOP    = 4'hF;

   typedef enum int {ENC_SHORT, ENC_EXT16, ENC_EXT64} len_enc_type;
   typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_CADENCE} ready_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;

   int fail_count;
   int beats_pending;
   int beats_checked;
   int truncated_beats;

   logic [7:0]     chunk_q[$];
   int             sent_count;
   int             chunk_count;
   int             burst_left;
   bit             pressure_on;
   bit             holdoff_done;
   ready_mode_type ready_mode;
   int             mode_left;

   websocket_frame_deframer #(
      .LENGTH_BITS(LEN_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   wsdf_frame_checker #(
      .LENGTH_BITS(LEN_BITS)
   ) checker_i (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .fail_count(fail_count),
      .beats_pending(beats_pending),
      .beats_checked(beats_checked),
      .truncated_beats(truncated_beats)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Add one byte to the end of the chunk being assembled.
   function automatic void append_byte(input logic [7:0] b);
      chunk_q.insert(chunk_q.size(), b);
   endfunction

   // Frame header with random reserved bits, big-endian length and key.
   function automatic void push_header(input logic fin, input logic [OPCODE_W-1:0] opc,
                                       input logic masked, input len_enc_type enc,
                                       input logic [63:0] len, input logic [31:0] key);
      append_byte({fin, 3'($urandom), opc});
      case (enc)
         ENC_SHORT: begin
            append_byte({masked, len[6:0]});
         end
         ENC_EXT16: begin
            append_byte({masked, LEN_EXT16});
            append_byte(len[15:8]);
            append_byte(len[7:0]);
         end
         default: begin
            append_byte({masked, LEN_EXT64});
            for (int i = 7; i >= 0; i--) begin
               append_byte(len[8*i +: 8]);
            end
         end
      endcase
      if (masked) begin
         for (int i = 3; i >= 0; i--) begin
            append_byte(key[8*i +: 8]);
         end
      end
   endfunction

   function automatic void trim_chunk(input int keep);
      while (chunk_q.size() > keep) begin
         void'(chunk_q.pop_back());
      end
   endfunction

   // Offer one byte, in bursts with random gaps between them.
   task automatic send_beat(input logic [7:0] b, input logic chunk_end);
      int gap;
      if (burst_left == 0) begin
         if (!pressure_on) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= chunk_end;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
   endtask

   // Send the assembled chunk, marking its last byte.
   task automatic send_chunk();
      for (int i = 0; i < chunk_q.size(); i++) begin
         send_beat(chunk_q[i], i == chunk_q.size() - 1);
      end
      chunk_q.delete();
      chunk_count++;
   endtask

   // Receiver readiness: changing stall modes, plus one long hold-off under load.
   initial begin
      rsp_tready <= 1'b0;
      mode_left = 0;
      ready_mode = RDY_ALWAYS;
      forever begin
         @(posedge clock);
         if (!holdoff_done && sent_count >= PRESSURE_AT) begin
            pressure_on = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            pressure_on = 1'b0;
            holdoff_done = 1'b1;
            rsp_tready <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               ready_mode = ready_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            case (ready_mode)
               RDY_ALWAYS:  rsp_tready <= 1'b1;
               RDY_COIN:    rsp_tready <= 1'($urandom_range(0, 1));
               RDY_SPARSE:  rsp_tready <= ($urandom_range(0, 3) == 0);
               default:     rsp_tready <= (mode_left % 3 != 0);
            endcase
         end
      end
   end

   // Run time limit
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Timed out after %0d cycles", CYCLE_LIMIT);
      $display("FAIL websocket_frame_deframer");
      $finish;
   end

   // Stimulus and verdict
   initial begin
      int              kind;
      int              pick;
      int              body_n;
      logic            fin;
      logic            masked;
      logic [OPCODE_W-1:0] opc;
      logic [31:0]     key;
      logic [63:0]     len;
      len_enc_type     enc;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      sent_count = 0;
      chunk_count = 0;
      burst_left = 0;
      pressure_on = 1'b0;
      holdoff_done = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Empty close frame: close code falls back to the default.
      push_header(1'b1, OPC_CLOSE, 1'b0, ENC_SHORT, 64'd0, 32'h0);
      send_chunk();
      // One masked byte under an all-ones key.
      push_header(1'b1, OPC_TEXT, 1'b1, ENC_SHORT, 64'd1, 32'hFFFF_FFFF);
      append_byte(8'h00);
      send_chunk();
      // Close frame with a status code and FIN clear.
      push_header(1'b0, OPC_CLOSE, 1'b0, ENC_SHORT, 64'd2, 32'h0);
      append_byte(8'h03);
      append_byte(8'hE9);
      send_chunk();
      // 16-bit length of zero with the highest opcode.
      push_header(1'b1, OPC_TOP, 1'b0, ENC_EXT16, 64'd0, 32'h0);
      send_chunk();
      // Close frame with a single payload byte keeps the default code.
      push_header(1'b1, OPC_CLOSE, 1'b0, ENC_SHORT, 64'd1, 32'h0);
      append_byte(8'hFF);
      send_chunk();
      // Chunk ends on the first header byte.
      push_header(1'b1, OPC_BINARY, 1'b1, ENC_SHORT, 64'd3, $urandom);
      trim_chunk(1);
      send_chunk();
      // 64-bit length with its top bit set; the chunk ends inside it.
      push_header(1'b0, OPC_CONT, 1'b0, ENC_EXT64, 64'h8000_0000_0000_0000, 32'h0);
      trim_chunk(4);
      send_chunk();
      // Bytes after a complete frame are dropped.
      push_header(1'b1, OPC_PONG, 1'b0, ENC_SHORT, 64'd1, 32'h0);
      append_byte(8'h5A);
      append_byte(8'h00);
      append_byte(8'hFF);
      send_chunk();

      // Mostly well-formed frames, with truncated, padded and noise chunks mixed in.
      while (sent_count < ITEM_TARGET) begin
         kind   = $urandom_range(0, 19);
         fin    = 1'($urandom_range(0, 1));
         opc    = ($urandom_range(0, 3) == 0) ? OPC_CLOSE : OPCODE_W'($urandom);
         masked = 1'($urandom_range(0, 1));
         key    = $urandom;
         pick   = $urandom_range(0, 15);
         if (pick < 10) begin
            len = 64'($urandom_range(0, 6));
         end else if (pick < 13) begin
            len = 64'($urandom_range(7, 125));
         end else if (pick == 13) begin
            len = 64'($urandom_range(0, 2));
         end else begin
            len = 64'($urandom_range(126, 300));
         end
         if (len > 64'd125) begin
            enc = ($urandom_range(0, 3) == 0) ? ENC_EXT64 : ENC_EXT16;
         end else if ($urandom_range(0, 7) == 0) begin
            // Non-minimal length encoding
            enc = ($urandom_range(0, 1) == 0) ? ENC_EXT64 : ENC_EXT16;
         end else begin
            enc = ENC_SHORT;
         end
         body_n = int'(len);
         if (kind == 19) begin
            // Huge 64-bit length: the chunk always ends first.
            len    = {$urandom, $urandom};
            enc    = ENC_EXT64;
            body_n = $urandom_range(0, 5);
         end
         push_header(fin, opc, masked, enc, len, key);
         repeat (body_n) append_byte(8'($urandom));
         if (kind == 14 || kind == 15) begin
            repeat ($urandom_range(1, 4)) append_byte(8'($urandom));
         end else if ((kind == 16 || kind == 17) && chunk_q.size() > 1) begin
            trim_chunk($urandom_range(1, chunk_q.size() - 1));
         end else if (kind == 18) begin
            chunk_q.delete();
            repeat ($urandom_range(1, 6)) append_byte(8'($urandom));
         end
         send_chunk();
      end
      req_tvalid <= 1'b0;

      // Drain the outstanding results, then allow for any late beat.
      do @(posedge clock); while (beats_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes in %0d chunks; checked %0d result beats, %0d of them truncated.",
               sent_count, chunk_count, beats_checked, truncated_beats);
      $display("The receiver held off for %0d cycles once while bytes kept coming.", HOLD_CYCLES);
      if (fail_count == 0 && beats_pending == 0) begin
         $display("PASS websocket_frame_deframer");
      end else begin
         $display("%0d mismatches, %0d results still expected", fail_count, beats_pending);
         $display("FAIL websocket_frame_deframer");
      end
      $finish;
   end

endmodule
